// File: rtl/servo_status_packet_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// Servo status packet parser - assertion macros
// Shared concurrent assertion forms used by the parser modules.
// ----------------------------------------------------------------------------
`ifndef SERVO_STATUS_PACKET_PARSER_UNIT_MACROS_SVH
`define SERVO_STATUS_PACKET_PARSER_UNIT_MACROS_SVH

// Check a consequent in the same cycle as the antecedent
`define SSPP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after the antecedent
`define SSPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sspp_pkg.sv
// ----------------------------------------------------------------------------
// sspp_pkg
// Types, constants and the CRC-16 byte update shared by the parser modules.
// ----------------------------------------------------------------------------
package sspp_pkg;

   // Framing limits
   localparam int MIN_STATUS_LEN   = 11;
   localparam int MAX_PACKET_BYTES = 128;
   localparam int LEN_W            = $clog2(MAX_PACKET_BYTES + 1);
   localparam int MAX_LEN_FIELD    = MAX_PACKET_BYTES - 7;

   // Header and instruction bytes
   localparam logic [7:0] HDR_FF       = 8'hFF;
   localparam logic [7:0] HDR_FD       = 8'hFD;
   localparam logic [7:0] HDR_00       = 8'h00;
   localparam logic [7:0] INSTR_STATUS = 8'h55;
   localparam logic [15:0] LEN_OVERHEAD = 16'd7;
   localparam logic [15:0] LEN_FIELD_MIN = 16'd3;

   // Byte positions inside a packet
   localparam logic [LEN_W-1:0] POS_ID     = LEN_W'(4);
   localparam logic [LEN_W-1:0] POS_LEN_LO = LEN_W'(5);
   localparam logic [LEN_W-1:0] POS_LEN_HI = LEN_W'(6);
   localparam logic [LEN_W-1:0] POS_INSTR  = LEN_W'(7);
   localparam logic [LEN_W-1:0] POS_PARAM  = LEN_W'(9);

   // Configuration register indexes
   localparam logic [1:0] CSR_REGISTER_BYTES   = 2'd0;
   localparam logic [1:0] CSR_CRC_CHECK_ENABLE = 2'd1;
   localparam logic [1:0] CSR_PING_MODE        = 2'd2;

   // Result kinds
   localparam logic KIND_REPORT  = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   // Summary status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_SHORT     = 2'd1;
   localparam logic [1:0] ST_NO_HEADER = 2'd2;
   localparam logic [1:0] ST_NO_VALID  = 2'd3;

   // Result queue depth
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef enum logic [0:0] {
      PH_HUNT = 1'b0,
      PH_BODY = 1'b1
   } phase_type;

   typedef struct packed {
      logic [2:0] register_bytes;
      logic       crc_check_enable;
      logic       ping_mode;
   } cfg_type;

   typedef struct packed {
      logic        result_kind;
      logic [7:0]  servo_id;
      logic [31:0] reg_value;
      logic [7:0]  valid_count;
      logic [1:0]  buffer_status;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } result_slot_type;

   // CRC-16, poly 0x8005, MSB first, one byte
   function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ 16'h8005;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   localparam logic [15:0] HDR_CRC =
      crc_add(crc_add(crc_add(crc_add(16'h0000, HDR_FF), HDR_FF), HDR_FD), HDR_00);

endpackage

// File: rtl/sspp_result_fifo.sv
// ----------------------------------------------------------------------------
// sspp_result_fifo
// Result queue: takes up to two results per cycle while it has room, hands out one per beat.
// ----------------------------------------------------------------------------
module sspp_result_fifo
   import sspp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  result_slot_type push_a,
   input  result_slot_type push_b,
   output logic            room,
   output logic            out_valid,
   input  logic            out_ready,
   output result_type      out_data
);

`include "servo_status_packet_parser_unit_macros.svh"

   result_type              mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]        count_ff, count_in;
   logic                    pop;
   logic [FIFO_AW:0]        n_push;

   assign room      = count_ff <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;
   assign n_push    = (FIFO_AW + 1)'(push_a.valid) + (FIFO_AW + 1)'(push_b.valid);

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_AW'(n_push);
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + n_push - (FIFO_AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries, report first when both arrive
   always_ff @(posedge clock) begin
      if (push_a.valid) begin
         mem_ff[wr_ptr_ff] <= push_a.data;
         if (push_b.valid) begin
            mem_ff[wr_ptr_ff + 1'b1] <= push_b.data;
         end
      end else if (push_b.valid) begin
         mem_ff[wr_ptr_ff] <= push_b.data;
      end
   end

   `SSPP_ASSERT_NOW(a_fifo_bound, clock, reset, 1'b1,
      count_ff <= (FIFO_AW + 1)'(FIFO_DEPTH), "result queue over capacity")
   `SSPP_ASSERT_NOW(a_fifo_push_room, clock, reset, push_a.valid || push_b.valid,
      room, "result pushed without room for two entries")
   `SSPP_ASSERT_NEXT(a_fifo_two_push, clock, reset,
      push_a.valid && push_b.valid && !pop, count_ff == $past(count_ff) + 2'd2,
      "double push lost an entry")

endmodule

// File: rtl/sspp_parser.sv
// ----------------------------------------------------------------------------
// sspp_parser
// Per-byte header hunt, field capture, CRC update and result build; holds
// the configuration registers.
// ----------------------------------------------------------------------------
module sspp_parser
   import sspp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [2:0]      csr_wdata,
   input  logic            fire,
   input  logic [7:0]      rx_byte,
   input  logic            end_of_buffer,
   output result_slot_type report,
   output result_slot_type summary
);

`include "servo_status_packet_parser_unit_macros.svh"

   cfg_type            cfg_ff, cfg_in;
   phase_type          phase_ff, phase_in;
   logic [1:0]         hdr_prog_ff, hdr_prog_in;
   logic [LEN_W-1:0]   pos_ff, pos_in;
   logic [LEN_W-1:0]   plen_ff, plen_in;
   logic [7:0]         len_lo_ff, len_lo_in;
   logic [15:0]        crc_ff, crc_in;
   logic [7:0]         crc_lo_ff, crc_lo_in;
   logic [7:0]         id_ff, id_in;
   logic [7:0]         instr_ff, instr_in;
   logic [31:0]        acc_ff, acc_in;
   logic [7:0]         byte_cnt_ff, byte_cnt_in;
   logic [7:0]         good_cnt_ff, good_cnt_in;
   logic               hdr_seen_ff, hdr_seen_in;

   logic [LEN_W:0]     pos_p2;
   logic [LEN_W:0]     plen_x;
   logic [15:0]        len_field;
   logic [2:0]         nbytes;
   logic [LEN_W-1:0]   lane;
   logic               pkt_ok;
   logic [1:0]         status;

   // Decode configuration writes
   always_comb begin
      cfg_in = cfg_ff;
      unique case (csr_index)
         CSR_REGISTER_BYTES:   cfg_in.register_bytes   = csr_wdata;
         CSR_CRC_CHECK_ENABLE: cfg_in.crc_check_enable = csr_wdata[0];
         CSR_PING_MODE:        cfg_in.ping_mode        = csr_wdata[0];
         default:              cfg_in = cfg_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{register_bytes: 3'd4, crc_check_enable: 1'b1, ping_mode: 1'b0};
      end else if (csr_we) begin
         cfg_ff <= cfg_in;
      end
   end

   assign pos_p2    = {1'b0, pos_ff} + (LEN_W + 1)'(2);
   assign plen_x    = {1'b0, plen_ff};
   assign len_field = {rx_byte, len_lo_ff};
   assign nbytes    = (cfg_ff.register_bytes > 3'd4) ? 3'd4 : cfg_ff.register_bytes;
   assign lane      = pos_ff - POS_PARAM;

   // Next parse state and results for one byte
   always_comb begin
      phase_in    = phase_ff;
      hdr_prog_in = hdr_prog_ff;
      pos_in      = pos_ff;
      plen_in     = plen_ff;
      len_lo_in   = len_lo_ff;
      crc_in      = crc_ff;
      crc_lo_in   = crc_lo_ff;
      id_in       = id_ff;
      instr_in    = instr_ff;
      acc_in      = acc_ff;
      hdr_seen_in = hdr_seen_ff;
      byte_cnt_in = (byte_cnt_ff == 8'hFF) ? byte_cnt_ff : byte_cnt_ff + 8'd1;
      pkt_ok      = 1'b0;

      unique case (phase_ff)
         PH_HUNT: begin
            if (hdr_prog_ff == 2'd3 && rx_byte == HDR_00) begin
               hdr_seen_in = 1'b1;
               hdr_prog_in = 2'd0;
               phase_in    = PH_BODY;
               pos_in      = POS_ID;
               crc_in      = HDR_CRC;
               acc_in      = '0;
               plen_in     = '0;
               len_lo_in   = '0;
            end else if (rx_byte == HDR_FF) begin
               hdr_prog_in = (hdr_prog_ff >= 2'd1) ? 2'd2 : 2'd1;
            end else if (rx_byte == HDR_FD && hdr_prog_ff == 2'd2) begin
               hdr_prog_in = 2'd3;
            end else begin
               hdr_prog_in = 2'd0;
            end
         end
         PH_BODY: begin
            pos_in = pos_ff + 1'b1;
            if (pos_p2 < plen_x || pos_ff < POS_INSTR) begin
               crc_in = crc_add(crc_ff, rx_byte);
            end
            if (pos_ff == POS_ID) begin
               id_in = rx_byte;
            end else if (pos_ff == POS_LEN_LO) begin
               len_lo_in = rx_byte;
            end else if (pos_ff == POS_LEN_HI) begin
               // drop lengths with no room for the fields or beyond the limit
               if (len_field < LEN_FIELD_MIN || len_field > 16'(MAX_LEN_FIELD)) begin
                  phase_in    = PH_HUNT;
                  hdr_prog_in = 2'd0;
               end else begin
                  plen_in = LEN_W'(len_field + LEN_OVERHEAD);
               end
            end else if (pos_ff == POS_INSTR) begin
               instr_in = rx_byte;
            end else if (pos_p2 < plen_x) begin
               if (pos_ff >= POS_PARAM && lane < LEN_W'(nbytes)) begin
                  acc_in = acc_ff | ({24'h0, rx_byte} << {lane[1:0], 3'b000});
               end
            end else if (pos_p2 == plen_x) begin
               crc_lo_in = rx_byte;
            end else begin
               // last CRC byte closes the packet
               pkt_ok = instr_ff == INSTR_STATUS &&
                        plen_ff >= LEN_W'(MIN_STATUS_LEN) &&
                        !(cfg_ff.crc_check_enable &&
                          (crc_lo_ff != crc_ff[7:0] || rx_byte != crc_ff[15:8]));
               phase_in    = PH_HUNT;
               hdr_prog_in = 2'd0;
            end
         end
         default: phase_in = PH_HUNT;
      endcase

      good_cnt_in = (pkt_ok && good_cnt_ff != 8'hFF) ? good_cnt_ff + 8'd1 : good_cnt_ff;
   end

   // Rank summary status: short buffer, then no header, then no packet
   always_comb begin
      if (byte_cnt_in < 8'(MIN_STATUS_LEN)) begin
         status = ST_SHORT;
      end else if (!hdr_seen_in) begin
         status = ST_NO_HEADER;
      end else if (good_cnt_in == 8'd0) begin
         status = ST_NO_VALID;
      end else begin
         status = ST_OK;
      end
   end

   // Build the two result slots
   always_comb begin
      report.valid              = fire && pkt_ok;
      report.data.result_kind   = KIND_REPORT;
      report.data.servo_id      = id_ff;
      report.data.reg_value     = cfg_ff.ping_mode ? 32'h0 : acc_ff;
      report.data.valid_count   = 8'h00;
      report.data.buffer_status = ST_OK;
      report.data.last_of_run   = !end_of_buffer;

      summary.valid              = fire && end_of_buffer;
      summary.data.result_kind   = KIND_SUMMARY;
      summary.data.servo_id      = 8'h00;
      summary.data.reg_value     = 32'h0;
      summary.data.valid_count   = good_cnt_in;
      summary.data.buffer_status = status;
      summary.data.last_of_run   = 1'b1;
   end

   // Update state on each byte; clear per-buffer state after a summary
   always_ff @(posedge clock) begin
      if (reset || (fire && end_of_buffer)) begin
         phase_ff    <= PH_HUNT;
         hdr_prog_ff <= '0;
         pos_ff      <= '0;
         plen_ff     <= '0;
         len_lo_ff   <= '0;
         crc_ff      <= '0;
         crc_lo_ff   <= '0;
         id_ff       <= '0;
         instr_ff    <= '0;
         acc_ff      <= '0;
         byte_cnt_ff <= '0;
         good_cnt_ff <= '0;
         hdr_seen_ff <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         hdr_prog_ff <= hdr_prog_in;
         pos_ff      <= pos_in;
         plen_ff     <= plen_in;
         len_lo_ff   <= len_lo_in;
         crc_ff      <= crc_in;
         crc_lo_ff   <= crc_lo_in;
         id_ff       <= id_in;
         instr_ff    <= instr_in;
         acc_ff      <= acc_in;
         byte_cnt_ff <= byte_cnt_in;
         good_cnt_ff <= good_cnt_in;
         hdr_seen_ff <= hdr_seen_in;
      end
   end

   `SSPP_ASSERT_NOW(a_body_pos, clock, reset, phase_ff == PH_BODY,
      pos_ff >= POS_ID, "packet body position below the ID byte")
   `SSPP_ASSERT_NEXT(a_eob_clear, clock, reset, fire && end_of_buffer,
      good_cnt_ff == 8'd0 && !hdr_seen_ff && phase_ff == PH_HUNT,
      "buffer state not cleared after summary")
   `SSPP_ASSERT_NOW(a_report_seen, clock, reset, report.valid,
      hdr_seen_ff, "packet reported without a header")

endmodule

// File: rtl/servo_status_packet_parser_unit.sv
// ----------------------------------------------------------------------------
// servo_status_packet_parser_unit
// Servo bus status packet parser: reports ID and register value of each
// good status packet and a per-buffer summary.
//
//   Channel   Dir  Handshake            Contents
//   req_*     in   tvalid/tready/tlast  tdata: rx_byte; tlast: end_of_buffer
//   rsp_*     out  tvalid/tready/tlast  tdata: id, value, count, status;
//                                       tuser: result_kind; tlast: last_of_run
//   csr_*     in   we                   index 0..2, data 3 bits
//
// One byte per cycle sustained while the queue has room. A byte is held in the input
// register and is parsed into a four-entry result queue; its results are registered
// there and appear on rsp_ in order. The input register advances only while the queue
// has room for two results, so a stalled rsp_ side backs up into req_tready.
// Synchronous reset clears the parse state, the queue and the configuration
// (register_bytes 4, CRC check on, ping mode off).
// ----------------------------------------------------------------------------
module servo_status_packet_parser_unit
   import sspp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // configuration write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [2:0]  csr_wdata,
   // received bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tlast,
   // results
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] servo_id, [39:8] reg_value,
                                    // [47:40] valid_count, [49:48] buffer_status
   output logic        rsp_tuser,   // [0] result_kind
   output logic        rsp_tlast
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_eob_ff;
   logic            room;
   logic            fire;
   result_slot_type report;
   result_slot_type summary;
   result_type      head;

   // Parse the held byte when the queue can take both results
   assign fire        = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || fire;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Hold payload until parsed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_eob_ff  <= req_tlast;
      end
   end

   sspp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fire          (fire),
      .rx_byte       (in_byte_ff),
      .end_of_buffer (in_eob_ff),
      .report        (report),
      .summary       (summary)
   );

   sspp_result_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_a    (report),
      .push_b    (summary),
      .room      (room),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   // Pack the result beat
   assign rsp_tdata = {6'b000000, head.buffer_status, head.valid_count,
                       head.reg_value, head.servo_id};
   assign rsp_tuser = head.result_kind;
   assign rsp_tlast = head.last_of_run;

endmodule
